// ----- src/obmt_pkg.sv -----
// Shared types and constants for the overlap box merge table.
`timescale 1ns / 1ps
`default_nettype none
package obmt_pkg;

  localparam int CB = 14;      // coordinate bits
  localparam int AW = 2 * CB;  // area and intersection bits
  localparam logic [CB-1:0] CMAX = {CB{1'b1}};

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_MERGE  = 2'd1,
    OP_APPEND = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_MERGED   = 3'd0,
    ST_APPENDED = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_FULL     = 3'd3,
    ST_CLEARED  = 3'd4,
    ST_READ_OK  = 3'd5,
    ST_READ_BAD = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SCAN,
    S_MERGE
  } state_t;

  typedef struct packed {
    logic [CB-1:0] x;
    logic [CB-1:0] y;
    logic [CB-1:0] w;
    logic [CB-1:0] h;
  } box_t;

  typedef struct packed {
    op_t           operation;
    logic [CB-1:0] box_x;
    logic [CB-1:0] box_y;
    logic [CB-1:0] box_width;
    logic [CB-1:0] box_height;
    logic [5:0]    read_index;
  } cmd_t;

  typedef struct packed {
    status_t       status;
    logic [5:0]    entry_index;
    logic [CB-1:0] entry_x;
    logic [CB-1:0] entry_y;
    logic [CB-1:0] entry_width;
    logic [CB-1:0] entry_height;
    logic [6:0]    entry_count;
  } res_t;

endpackage
`default_nettype wire

// ----- src/obmt_match.sv -----
// Overlap test pipeline: spans, products, then the two threshold compares.
`timescale 1ns / 1ps
`default_nettype none
module obmt_match
  import obmt_pkg::*;
#(
  parameter int IW = 6
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          flush,
  input  wire logic          in_valid,
  input  wire logic [IW-1:0] in_idx,
  input  wire box_t          in_box,
  input  wire box_t          cand,
  input  wire logic [AW-1:0] cand_area,
  output logic               hit,
  output logic [IW-1:0]      hit_idx,
  output box_t               hit_box,
  output logic               pending
);

  function automatic logic [CB-1:0] span_overlap(input logic [CB-1:0] a0,
      input logic [CB-1:0] al, input logic [CB-1:0] b0, input logic [CB-1:0] bl);
    logic [CB-1:0] lo;
    logic [CB:0]   ea;
    logic [CB:0]   eb;
    logic [CB:0]   hi;
    logic [CB:0]   d;
    lo = (a0 > b0) ? a0 : b0;
    ea = {1'b0, a0} + {1'b0, al};
    eb = {1'b0, b0} + {1'b0, bl};
    hi = (ea < eb) ? ea : eb;
    d  = hi - {1'b0, lo};
    return (hi > {1'b0, lo}) ? d[CB-1:0] : '0;
  endfunction

  logic          s2_valid;
  logic [IW-1:0] s2_idx;
  box_t          s2_box;
  logic [CB-1:0] s2_ox;
  logic [CB-1:0] s2_oy;

  logic          s3_valid;
  logic [IW-1:0] s3_idx;
  box_t          s3_box;
  logic [AW-1:0] s3_inter;
  logic [AW-1:0] s3_area;

  always_ff @(posedge clk) begin
    if (rst || flush) begin
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s2_valid <= in_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_idx   <= in_idx;
    s2_box   <= in_box;
    s2_ox    <= span_overlap(in_box.x, in_box.w, cand.x, cand.w);
    s2_oy    <= span_overlap(in_box.y, in_box.h, cand.y, cand.h);
    s3_idx   <= s2_idx;
    s3_box   <= s2_box;
    s3_inter <= AW'(s2_ox) * AW'(s2_oy);
    s3_area  <= AW'(s2_box.w) * AW'(s2_box.h);
  end

  logic [AW+2:0] inter5;
  logic [AW:0]   area_sum;
  logic [AW-1:0] area_min;
  logic [AW+4:0] inter20;
  logic [AW+3:0] min9;

  // 5*inter > sum of areas, or 20*inter > 9*smaller area
  always_comb begin
    inter5   = {1'b0, s3_inter, 2'b00} + {3'b000, s3_inter};
    area_sum = {1'b0, s3_area} + {1'b0, cand_area};
    area_min = (s3_area < cand_area) ? s3_area : cand_area;
    inter20  = {1'b0, s3_inter, 4'b0000} + {3'b000, s3_inter, 2'b00};
    min9     = {1'b0, area_min, 3'b000} + {4'b0000, area_min};
    hit      = s3_valid && ((inter5 > (AW+3)'(area_sum)) || (inter20 > {1'b0, min9}));
  end

  assign hit_idx = s3_idx;
  assign hit_box = s3_box;
  assign pending = s2_valid || s3_valid;

endmodule
`default_nettype wire

// ----- src/overlap_box_merge_table.sv -----
// Box table with greedy overlap merge, built around one synchronous entry memory.
//
//   channel  handshake                   word    what it carries
//   command  start, taken when busy low  cmd_t   operation, candidate box, read index
//   result   done, one-cycle strobe      res_t   status, entry index, entry box, count
//
// Clear, append, empty, full and bad-read commands, and a merge-insert into an
// empty table, answer in the cycle after they are taken.
// A read first reads the memory, then registers the word in the result.
// A merge-insert walks the entries one per memory read through a three-stage
// compare pipeline; the first match is merged in S_MERGE, and with no match the
// box is appended (or reported full) once the pipeline has drained.
// rst is synchronous and empties the table; entry contents are not cleared.
// The receiver cannot stall; done is raised once for every command taken.
`timescale 1ns / 1ps
`default_nettype none
module overlap_box_merge_table
  import obmt_pkg::*;
#(
  parameter int MAX_BOXES = 64
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire cmd_t cmd,
  output logic      busy,
  output logic      done,
  output res_t      result
);

  localparam int IW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int CW = $clog2(MAX_BOXES + 1);
  localparam int KW = (CW > 6) ? CW + 1 : 7;

  function automatic void span_union(input logic [CB-1:0] a0, input logic [CB-1:0] al,
      input logic [CB-1:0] b0, input logic [CB-1:0] bl,
      output logic [CB-1:0] p0, output logic [CB-1:0] pl);
    logic [CB:0] ea;
    logic [CB:0] eb;
    logic [CB:0] hi;
    logic [CB:0] len;
    ea  = {1'b0, a0} + {1'b0, al};
    eb  = {1'b0, b0} + {1'b0, bl};
    hi  = (ea > eb) ? ea : eb;
    p0  = (a0 < b0) ? a0 : b0;
    len = hi - {1'b0, p0};
    pl  = (len > {1'b0, CMAX}) ? CMAX : len[CB-1:0];
  endfunction

  box_t mem [MAX_BOXES];

  state_t        state;
  state_t        state_next;
  logic [CW-1:0] valid_count;
  logic [CW-1:0] valid_count_next;
  logic [CW-1:0] scan_cnt;
  logic [CW-1:0] scan_cnt_next;
  logic          tag_v;
  logic          tag_v_next;
  logic [IW-1:0] tag_idx;
  logic [IW-1:0] tag_idx_next;
  box_t          rdata;
  logic [IW-1:0] rd_addr;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  box_t          wr_data;
  box_t          cand;
  logic [AW-1:0] cand_area;
  logic [5:0]    rd_idx;
  box_t          m_box;
  logic [IW-1:0] m_idx;
  res_t          res_next;
  logic          done_next;
  logic          flush;
  logic          accept;

  logic          hit;
  logic [IW-1:0] hit_idx;
  box_t          hit_box;
  logic          pending;

  box_t          in_box;
  box_t          cur_box;
  box_t          u_box;
  logic          full;
  logic          in_empty;
  logic          rd_ok;
  res_t          app_res;
  logic [CW-1:0] app_count;

  assign accept = start && (state == S_IDLE);
  assign busy   = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata <= mem[rd_addr];
  end

  obmt_match #(
    .IW(IW)
  ) u_match (
    .clk      (clk),
    .rst      (rst),
    .flush    (flush),
    .in_valid (tag_v),
    .in_idx   (tag_idx),
    .in_box   (rdata),
    .cand     (cand),
    .cand_area(cand_area),
    .hit      (hit),
    .hit_idx  (hit_idx),
    .hit_box  (hit_box),
    .pending  (pending)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      valid_count <= '0;
      scan_cnt    <= '0;
      tag_v       <= 1'b0;
      done        <= 1'b0;
    end else begin
      state       <= state_next;
      valid_count <= valid_count_next;
      scan_cnt    <= scan_cnt_next;
      tag_v       <= tag_v_next;
      done        <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    tag_idx <= tag_idx_next;
    result  <= res_next;
    if (accept) begin
      cand      <= in_box;
      cand_area <= AW'(cmd.box_width) * AW'(cmd.box_height);
      rd_idx    <= cmd.read_index;
    end
    if (state == S_SCAN && hit) begin
      m_box <= hit_box;
      m_idx <= hit_idx;
    end
  end

  always_comb begin
    in_box   = '{x: cmd.box_x, y: cmd.box_y, w: cmd.box_width, h: cmd.box_height};
    cur_box  = (state == S_IDLE) ? in_box : cand;
    full     = (valid_count == CW'(MAX_BOXES));
    in_empty = (cmd.box_width == '0) || (cmd.box_height == '0);
    rd_ok    = (KW'(cmd.read_index) < KW'(valid_count));
    span_union(m_box.x, m_box.w, cand.x, cand.w, u_box.x, u_box.w);
    span_union(m_box.y, m_box.h, cand.y, cand.h, u_box.y, u_box.h);

    app_count = valid_count + CW'(1);
    if (full) begin
      app_res = '{status: ST_FULL, entry_index: '0, entry_x: '0, entry_y: '0,
                  entry_width: '0, entry_height: '0, entry_count: 7'(valid_count)};
    end else begin
      app_res = '{status: ST_APPENDED, entry_index: 6'(valid_count),
                  entry_x: cur_box.x, entry_y: cur_box.y, entry_width: cur_box.w,
                  entry_height: cur_box.h, entry_count: 7'(app_count)};
    end
  end

  always_comb begin
    state_next       = state;
    valid_count_next = valid_count;
    scan_cnt_next    = scan_cnt;
    tag_v_next       = 1'b0;
    tag_idx_next     = scan_cnt[IW-1:0];
    rd_addr          = scan_cnt[IW-1:0];
    wr_en            = 1'b0;
    wr_addr          = valid_count[IW-1:0];
    wr_data          = cur_box;
    res_next         = result;
    done_next        = 1'b0;
    flush            = 1'b0;

    case (state)
      S_IDLE: begin
        rd_addr = (cmd.operation == OP_READ) ? IW'(cmd.read_index) : '0;
        if (start) begin
          case (cmd.operation)
            OP_CLEAR: begin
              valid_count_next = '0;
              res_next  = '{status: ST_CLEARED, entry_index: '0, entry_x: '0,
                            entry_y: '0, entry_width: '0, entry_height: '0,
                            entry_count: '0};
              done_next = 1'b1;
            end
            OP_READ: begin
              if (rd_ok) begin
                state_next = S_READ;
              end else begin
                res_next  = '{status: ST_READ_BAD, entry_index: cmd.read_index,
                              entry_x: '0, entry_y: '0, entry_width: '0,
                              entry_height: '0, entry_count: 7'(valid_count)};
                done_next = 1'b1;
              end
            end
            default: begin
              if (in_empty) begin
                res_next  = '{status: ST_EMPTY, entry_index: '0, entry_x: '0,
                              entry_y: '0, entry_width: '0, entry_height: '0,
                              entry_count: 7'(valid_count)};
                done_next = 1'b1;
              end else if (cmd.operation == OP_APPEND || valid_count == '0) begin
                wr_en     = !full;
                res_next  = app_res;
                done_next = 1'b1;
                if (!full) begin
                  valid_count_next = app_count;
                end
              end else begin
                // entry 0 is read at this edge; walk from entry 1 on
                state_next    = S_SCAN;
                tag_v_next    = 1'b1;
                tag_idx_next  = '0;
                scan_cnt_next = CW'(1);
              end
            end
          endcase
        end
      end

      S_READ: begin
        res_next   = '{status: ST_READ_OK, entry_index: rd_idx, entry_x: rdata.x,
                       entry_y: rdata.y, entry_width: rdata.w, entry_height: rdata.h,
                       entry_count: 7'(valid_count)};
        done_next  = 1'b1;
        state_next = S_IDLE;
      end

      S_SCAN: begin
        if (hit) begin
          // first match wins: drop everything behind it
          flush      = 1'b1;
          state_next = S_MERGE;
        end else if (scan_cnt < valid_count) begin
          tag_v_next    = 1'b1;
          scan_cnt_next = scan_cnt + CW'(1);
        end else if (!tag_v && !pending) begin
          wr_en      = !full;
          res_next   = app_res;
          done_next  = 1'b1;
          state_next = S_IDLE;
          if (!full) begin
            valid_count_next = app_count;
          end
        end
      end

      S_MERGE: begin
        wr_en      = 1'b1;
        wr_addr    = m_idx;
        wr_data    = u_box;
        res_next   = '{status: ST_MERGED, entry_index: 6'(m_idx), entry_x: u_box.x,
                       entry_y: u_box.y, entry_width: u_box.w, entry_height: u_box.h,
                       entry_count: 7'(valid_count)};
        done_next  = 1'b1;
        state_next = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- test/obmt_result_checker.sv -----
// Result checker for the overlap box merge table: tracks the box table and compares each word.
`timescale 1ns / 1ps
module obmt_result_checker
  import obmt_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire logic busy,
  input  wire cmd_t cmd,
  input  wire logic done,
  input  wire res_t result,
  output int        fails,
  output int        outstanding,
  output int        n_checked,
  output int        n_merged,
  output int        n_appended,
  output int        n_full,
  output int        n_reads
);

  localparam int TABLE_DEPTH = 64;

  box_t        shadow_boxes [TABLE_DEPTH];
  int unsigned shadow_count;
  res_t        pending_results [$];

  function automatic longint unsigned overlap_len(input longint unsigned a0,
                                                  input longint unsigned al,
                                                  input longint unsigned b0,
                                                  input longint unsigned bl);
    longint unsigned lo;
    longint unsigned hi;
    lo = (a0 > b0) ? a0 : b0;
    hi = (a0 + al < b0 + bl) ? a0 + al : b0 + bl;
    return (hi > lo) ? hi - lo : 64'd0;
  endfunction

  // Bounding span of two intervals; the length saturates at the coordinate range.
  function automatic void span_union(input longint unsigned a0, input longint unsigned al,
                                     input longint unsigned b0, input longint unsigned bl,
                                     output logic [CB-1:0] lo, output logic [CB-1:0] len);
    longint unsigned lo_w;
    longint unsigned hi_w;
    lo_w = (a0 < b0) ? a0 : b0;
    hi_w = (a0 + al > b0 + bl) ? a0 + al : b0 + bl;
    lo   = lo_w[CB-1:0];
    len  = (hi_w - lo_w > CMAX) ? CMAX : CB'(hi_w - lo_w);
  endfunction

  function automatic bit boxes_overlap(input box_t e, input box_t c);
    longint unsigned inter;
    longint unsigned area_e;
    longint unsigned area_c;
    longint unsigned area_min;
    longint unsigned ew;
    longint unsigned eh;
    longint unsigned cw;
    longint unsigned ch;
    ew = e.w;
    eh = e.h;
    cw = c.w;
    ch = c.h;
    inter    = overlap_len(e.x, ew, c.x, cw) * overlap_len(e.y, eh, c.y, ch);
    area_e   = ew * eh;
    area_c   = cw * ch;
    area_min = (area_e < area_c) ? area_e : area_c;
    return (5 * inter > area_e + area_c) || (20 * inter > 9 * area_min);
  endfunction

  // Update the shadow table for one command and return the word it should produce.
  function automatic res_t apply_command(input cmd_t c);
    res_t r;
    box_t cand;
    box_t e;
    int   i;
    bit   found;
    r     = '0;
    found = 1'b0;
    cand  = '{x: c.box_x, y: c.box_y, w: c.box_width, h: c.box_height};
    case (c.operation)
      OP_CLEAR: begin
        shadow_count = 0;
        r.status     = ST_CLEARED;
      end
      OP_READ: begin
        r.entry_index = c.read_index;
        if (c.read_index < shadow_count) begin
          e              = shadow_boxes[c.read_index];
          r.status       = ST_READ_OK;
          r.entry_x      = e.x;
          r.entry_y      = e.y;
          r.entry_width  = e.w;
          r.entry_height = e.h;
        end else begin
          r.status = ST_READ_BAD;
        end
      end
      default: begin
        if (cand.w == 0 || cand.h == 0) begin
          r.status = ST_EMPTY;
        end else begin
          if (c.operation == OP_MERGE) begin
            for (i = 0; i < shadow_count && !found; i++) begin
              e = shadow_boxes[i];
              if (boxes_overlap(e, cand)) begin
                span_union(e.x, e.w, cand.x, cand.w, e.x, e.w);
                span_union(e.y, e.h, cand.y, cand.h, e.y, e.h);
                shadow_boxes[i] = e;
                found           = 1'b1;
                r.status        = ST_MERGED;
                r.entry_index   = i[5:0];
                r.entry_x       = e.x;
                r.entry_y       = e.y;
                r.entry_width   = e.w;
                r.entry_height  = e.h;
              end
            end
          end
          if (!found) begin
            if (shadow_count >= TABLE_DEPTH) begin
              r.status = ST_FULL;
            end else begin
              shadow_boxes[shadow_count] = cand;
              r.status       = ST_APPENDED;
              r.entry_index  = shadow_count[5:0];
              r.entry_x      = cand.x;
              r.entry_y      = cand.y;
              r.entry_width  = cand.w;
              r.entry_height = cand.h;
              shadow_count++;
            end
          end
        end
      end
    endcase
    r.entry_count = shadow_count[6:0];
    return r;
  endfunction

  task automatic compare_field(input string fname, input logic [15:0] want,
                               input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", fname, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin : watch
    res_t want;
    if (rst) begin
      shadow_count = 0;
      pending_results.delete();
    end else begin
      // Check the returning word first: it always belongs to an earlier command.
      if (done) begin
        if (pending_results.size() == 0) begin
          $error("result word with no command outstanding: %h", result);
          fails++;
        end else begin
          want = pending_results.pop_front();
          compare_field("status", want.status, result.status);
          compare_field("entry_index", want.entry_index, result.entry_index);
          compare_field("entry_x", want.entry_x, result.entry_x);
          compare_field("entry_y", want.entry_y, result.entry_y);
          compare_field("entry_width", want.entry_width, result.entry_width);
          compare_field("entry_height", want.entry_height, result.entry_height);
          compare_field("entry_count", want.entry_count, result.entry_count);
          n_checked++;
          case (want.status)
            ST_MERGED:                n_merged++;
            ST_APPENDED:              n_appended++;
            ST_FULL:                  n_full++;
            ST_READ_OK, ST_READ_BAD:  n_reads++;
            default: ;
          endcase
        end
      end
      if (start && !busy) begin
        pending_results = {pending_results, apply_command(cmd)};
      end
    end
    outstanding = pending_results.size();
  end

endmodule

// ----- test/overlap_box_merge_table_tb.sv -----
// Testbench top for the overlap box merge table: command stimulus, reset and verdict.
`timescale 1ns / 1ps
module overlap_box_merge_table_tb;
  import obmt_pkg::*;

  localparam int RANDOM_ITEMS = 1200;
  localparam int CYCLE_LIMIT  = 1000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  cmd_t cmd = '0;
  logic busy;
  logic done;
  res_t result;

  int fails;
  int outstanding;
  int n_checked;
  int n_merged;
  int n_appended;
  int n_full;
  int n_reads;

  int cycles = 0;
  int idle_pct = 0;
  int n_sent = 0;

  always #6 clk = ~clk;

  overlap_box_merge_table #(
    .MAX_BOXES(64)
  ) i_dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done),
    .result(result)
  );

  obmt_result_checker i_result_check (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .cmd        (cmd),
    .done       (done),
    .result     (result),
    .fails      (fails),
    .outstanding(outstanding),
    .n_checked  (n_checked),
    .n_merged   (n_merged),
    .n_appended (n_appended),
    .n_full     (n_full),
    .n_reads    (n_reads)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("overlap_box_merge_table verification failed");
      $finish;
    end
  end

  function automatic cmd_t mk_cmd(input op_t op, input int x, input int y, input int w,
                                  input int h, input int ri);
    cmd_t c;
    c.operation  = op;
    c.box_x      = x[CB-1:0];
    c.box_y      = y[CB-1:0];
    c.box_width  = w[CB-1:0];
    c.box_height = h[CB-1:0];
    c.read_index = ri[5:0];
    return c;
  endfunction

  // Offer one word, optionally after an idle gap with junk on the bus, and hold until taken.
  task automatic send_cmd(input cmd_t c);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      cmd   <= cmd_t'({$urandom, $urandom});
      do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
    start <= 1'b1;
    cmd   <= c;
    do @(posedge clk); while (busy);
    if (!((c.operation == OP_MERGE || c.operation == OP_APPEND) &&
          (c.box_width == 0 || c.box_height == 0))) begin
      n_sent++;
    end
  endtask

  task automatic run_directed();
    send_cmd(mk_cmd(OP_CLEAR, 0, 0, 0, 0, 0));
    send_cmd(mk_cmd(OP_READ, 0, 0, 0, 0, 0));
    send_cmd(mk_cmd(OP_MERGE, 16383, 16383, 0, 16383, 63));
    send_cmd(mk_cmd(OP_APPEND, 16383, 16383, 16383, 0, 63));
    send_cmd(mk_cmd(OP_APPEND, 0, 0, 16000, 16000, 0));
    // union runs past the coordinate range and must saturate
    send_cmd(mk_cmd(OP_MERGE, 1000, 1000, 16383, 16383, 0));
    send_cmd(mk_cmd(OP_READ, 0, 0, 0, 0, 0));
    send_cmd(mk_cmd(OP_READ, 0, 0, 0, 0, 63));
    send_cmd(mk_cmd(OP_APPEND, 16383, 16383, 16383, 16383, 0));
    send_cmd(mk_cmd(OP_READ, 0, 0, 0, 0, 1));
    send_cmd(mk_cmd(OP_CLEAR, 16383, 16383, 16383, 16383, 63));
    send_cmd(mk_cmd(OP_APPEND, 0, 0, 1000, 1000, 0));
    // small box inside a big one: only the smaller-area rule fires
    send_cmd(mk_cmd(OP_MERGE, 10, 10, 10, 10, 0));
    send_cmd(mk_cmd(OP_MERGE, 4000, 4000, 100, 100, 0));
    // exactly at the IoU threshold: no merge
    send_cmd(mk_cmd(OP_MERGE, 4060, 4000, 100, 100, 0));
    // one pixel over: matches two entries, the first one wins
    send_cmd(mk_cmd(OP_MERGE, 4059, 4000, 100, 100, 0));
    send_cmd(mk_cmd(OP_APPEND, 2000, 2000, 100, 100, 0));
    send_cmd(mk_cmd(OP_MERGE, 2090, 2000, 100, 100, 0));
    send_cmd(mk_cmd(OP_APPEND, 0, 0, 1000, 1000, 0));
    send_cmd(mk_cmd(OP_READ, 0, 0, 0, 0, 2));
    send_cmd(mk_cmd(OP_READ, 0, 0, 0, 0, 5));
    send_cmd(mk_cmd(OP_READ, 0, 0, 0, 0, 6));
    send_cmd(mk_cmd(OP_READ, 0, 0, 0, 0, 42));
  endtask

  // Fill the table with disjoint boxes, then probe every full-table case.
  task automatic run_fill();
    int k;
    send_cmd(mk_cmd(OP_CLEAR, 0, 0, 0, 0, 0));
    send_cmd(mk_cmd(OP_MERGE, 100, 100, 200, 200, 0));
    for (k = 1; k < 64; k++) begin
      send_cmd(mk_cmd(OP_MERGE, (k % 8) * 2000 + $urandom_range(0, 999),
                      (k / 8) * 2000 + $urandom_range(0, 999),
                      $urandom_range(1, 900), $urandom_range(1, 900), 0));
    end
    send_cmd(mk_cmd(OP_MERGE, 16100, 16100, 200, 200, 0));
    send_cmd(mk_cmd(OP_MERGE, 150, 150, 100, 100, 0));
    send_cmd(mk_cmd(OP_APPEND, 16100, 16100, $urandom_range(1, 283), 1, 0));
    send_cmd(mk_cmd(OP_MERGE, 16100, 16100, 0, 5, 0));
    send_cmd(mk_cmd(OP_READ, 0, 0, 0, 0, 63));
    send_cmd(mk_cmd(OP_READ, 0, 0, 0, 0, $urandom_range(0, 63)));
  endtask

  // Boxes packed into one window so that merges chain onto a few entries.
  task automatic run_cluster(input int n);
    int   k;
    int   roll;
    int   bx;
    int   by;
    int   span;
    cmd_t c;
    bx   = $urandom_range(0, 16383);
    by   = $urandom_range(0, 16383);
    roll = $urandom_range(0, 9);
    span = (roll < 5) ? 32 : (roll < 8) ? 512 : 16383;
    if ($urandom_range(0, 3) != 0) send_cmd(mk_cmd(OP_CLEAR, 0, 0, 0, 0, 0));
    for (k = 0; k < n; k++) begin
      roll = $urandom_range(0, 99);
      c = mk_cmd(OP_MERGE, bx + $urandom_range(0, span), by + $urandom_range(0, span),
                 $urandom_range(1, span), $urandom_range(1, span), $urandom_range(0, 63));
      if (roll >= 62) c.operation = OP_APPEND;
      if (roll >= 72) c.operation = OP_READ;
      if (roll >= 92 && roll < 94) c.operation = OP_CLEAR;
      if (roll >= 94) c.read_index = $urandom_range(0, 15);
      if ($urandom_range(0, 99) < 4) c.box_width = '0;
      if ($urandom_range(0, 99) < 4) c.box_height = '0;
      send_cmd(c);
    end
  endtask

  task automatic run_noise(input int n);
    int k;
    for (k = 0; k < n; k++) send_cmd(cmd_t'({$urandom, $urandom}));
  endtask

  initial begin : stimulus
    int phase_idle [3];
    int p;
    int roll;
    int base;
    phase_idle = '{0, 48, 17};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    base = n_sent;
    for (p = 0; p < 3; p++) begin
      idle_pct = phase_idle[p];
      if (p == 0) run_fill();
      while (n_sent - base < (p + 1) * RANDOM_ITEMS / 3) begin
        roll = $urandom_range(0, 99);
        if (roll < 72) run_cluster($urandom_range(20, 80));
        else if (roll < 80) run_fill();
        else run_noise($urandom_range(10, 30));
      end
    end
    start <= 1'b0;
    // let the checker count the last word taken before polling
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    $display("Sent %0d commands, checked %0d result words over three idle settings.",
             n_sent, n_checked);
    $display("Merges %0d, appends %0d, table-full %0d, reads %0d.",
             n_merged, n_appended, n_full, n_reads);
    if (fails == 0 && outstanding == 0) begin
      $display("overlap_box_merge_table verification clean");
    end else begin
      $display("overlap_box_merge_table verification failed");
    end
    $finish;
  end

endmodule
